// ===== rtl/core/integer_to_radix_ascii_defines.svh =====
// assertion macros for the integer to radix ascii converter
// depends on: a clock named clk and an active-low reset named rst_n in scope
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ITRA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itra check failed (same cycle)");

// next-cycle implication, checked outside reset
`define ITRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itra check failed (next cycle)");

`endif

// ===== rtl/core/itra_pkg.sv =====
// shared types, codes and the digit character table for the radix converter
// no dependencies
package itra_pkg;

    localparam int VALUE_W   = 32;
    localparam int RADIX_W   = 8;
    localparam int PAD_W     = 8;
    localparam int DIVISOR_W = 5;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 8;

    typedef enum logic [1:0] {
        CMD_UNSIGNED = 2'd0,
        CMD_SIGNED   = 2'd1,
        CMD_PADDED   = 2'd2
    } itra_cmd_t;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_RADIX_ERR = 1'b1;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd16;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        return DIGIT_CHARS[d];
    endfunction

    typedef struct packed {
        logic                 start;
        logic [VALUE_W-1:0]   dividend;
        logic [DIVISOR_W-1:0] divisor;
    } itra_div_req_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainder;
    } itra_div_rsp_t;

endpackage

// ===== rtl/core/itra_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module itra_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/itra_div.sv =====
// iterative divider of a 32-bit value by a radix of at most 16, 8 quotient bits a cycle
// depends on: itra_pkg
module itra_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  itra_pkg::itra_div_req_t req,
    output itra_pkg::itra_div_rsp_t rsp
);
    import itra_pkg::*;

    localparam int STEP_BITS = 8;
    localparam int STEPS     = VALUE_W / STEP_BITS;
    localparam int CNT_W     = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   dvd_reg, dvd_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [DIVISOR_W-1:0] divisor_reg, divisor_next;

    logic [VALUE_W-1:0]   dvd_step;
    logic [DIGIT_W-1:0]   rem_step;
    logic [DIGIT_W:0]     trial;
    logic                 qbit;

    // restoring division, msb first; remainder stays below the divisor
    always_comb
    begin
        dvd_step = dvd_reg;
        rem_step = rem_reg;
        trial    = '0;
        qbit     = 1'b0;
        for (int j = 0; j < STEP_BITS; j++)
        begin
            trial = {rem_step, dvd_step[VALUE_W-1]};
            qbit  = (trial >= divisor_reg);
            if (qbit)
            begin
                rem_step = DIGIT_W'(trial - divisor_reg);
            end
            else
            begin
                rem_step = trial[DIGIT_W-1:0];
            end
            dvd_step = {dvd_step[VALUE_W-2:0], qbit};
        end
    end

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            dvd_next     = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_step;
            rem_next = rem_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== rtl/core/integer_to_radix_ascii.sv =====
// integer to radix ascii converter: top level sequencer and output register
// depends on: itra_pkg, itra_div, itra_ram, integer_to_radix_ascii_defines.svh
//
//  channel | dir | payload
//  s_axis  | in  | tdata: value[31:0], radix[39:32], pad_length[47:40]; tuser: command
//  m_axis  | out | tdata: character; tlast: last; tuser: status
//
// one request at a time: ready only while idle
// each digit takes one pass of the shared divider (4 steps of 8 bits plus handoff),
// each pad digit one buffer write, each emitted character a buffer read, load and handoff
// a bad radix answers in the next cycle with a single error character
// output stalls hold the character register; rst_n clears only control state
`include "integer_to_radix_ascii_defines.svh"

module integer_to_radix_ascii #(
    parameter int MAX_DIGITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // value[31:0], radix[39:32], pad_length[47:40]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // character[7:0]
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // status[0]
);
    import itra_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DIGITS);
    localparam logic [CW-1:0] ONE_CNT = CW'(1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_PAD   = 7'b0000100,
        S_SIGN  = 7'b0001000,
        S_FETCH = 7'b0010000,
        S_LOAD  = 7'b0100000,
        S_HOLD  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         n_reg, n_next;          // digits held in the buffer
    logic [CW-1:0]         pad_reg, pad_next;      // minimum digit count, zero if unpadded
    logic                  neg_reg, neg_next;
    logic [DIVISOR_W-1:0]  radix_reg, radix_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  status_reg, status_next;

    // request fields
    logic [VALUE_W-1:0]    in_value;
    logic [RADIX_W-1:0]    in_radix;
    logic [PAD_W-1:0]      in_pad;
    itra_cmd_t             in_cmd;
    logic                  in_neg;
    logic [VALUE_W-1:0]    in_mag;
    logic                  radix_ok;
    logic [CW-1:0]         in_pad_sat;

    logic [CW-1:0]         n_inc;
    itra_div_req_t         div_req;
    itra_div_rsp_t         div_rsp;

    logic                  ram_we;
    logic [DIGIT_W-1:0]    ram_wdata;
    logic [DIGIT_W-1:0]    ram_rdata;

    assign in_value = s_axis_tdata[31:0];
    assign in_radix = s_axis_tdata[39:32];
    assign in_pad   = s_axis_tdata[47:40];
    assign in_cmd   = itra_cmd_t'(s_axis_tuser);

    // magnitude as unsigned so the most negative value converts too
    assign in_neg   = (in_cmd == CMD_SIGNED) && in_value[VALUE_W-1];
    assign in_mag   = in_neg ? (~in_value + 1'b1) : in_value;
    assign radix_ok = (in_radix >= RADIX_MIN) && (in_radix <= RADIX_MAX);

    // padding only in padded mode, saturated at the buffer depth
    always_comb
    begin
        in_pad_sat = '0;
        if (in_cmd == CMD_PADDED)
        begin
            if (in_pad > PAD_W'(MAX_DIGITS))
            begin
                in_pad_sat = MAX_CNT;
            end
            else
            begin
                in_pad_sat = CW'(in_pad);
            end
        end
    end

    assign n_inc = n_reg + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        pad_next     = pad_reg;
        neg_next     = neg_reg;
        radix_next   = radix_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        status_next  = status_reg;
        div_req      = '0;
        div_req.dividend = in_mag;
        div_req.divisor  = in_radix[DIVISOR_W-1:0];
        ram_we       = 1'b0;
        ram_wdata    = div_rsp.remainder;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (!radix_ok)
                    begin
                        // error answer, buffer left untouched
                        char_next   = CHAR_NONE;
                        last_next   = 1'b1;
                        status_next = STATUS_RADIX_ERR;
                        state_next  = S_HOLD;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        neg_next      = in_neg;
                        pad_next      = in_pad_sat;
                        radix_next    = in_radix[DIVISOR_W-1:0];
                        n_next        = '0;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                div_req.dividend = div_rsp.quotient;
                div_req.divisor  = radix_reg;
                if (div_rsp.done)
                begin
                    // store the digit, least significant first
                    ram_we = 1'b1;
                    n_next = n_inc;
                    if ((div_rsp.quotient != '0) && (n_inc < MAX_CNT))
                    begin
                        div_req.start = 1'b1;
                    end
                    else if (n_inc < pad_reg)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        state_next = S_SIGN;
                    end
                end
            end
            S_PAD:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                n_next    = n_inc;
                if (n_inc >= pad_reg)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                if (neg_reg)
                begin
                    char_next   = CHAR_MINUS;
                    last_next   = 1'b0;
                    status_next = STATUS_OK;
                    state_next  = S_HOLD;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // buffer read of the top remaining digit is in flight
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                char_next   = digit_char(ram_rdata);
                last_next   = (n_reg == ONE_CNT);
                status_next = STATUS_OK;
                n_next      = n_reg - 1'b1;
                state_next  = S_HOLD;
            end
            S_HOLD:
            begin
                if (m_axis_tready)
                begin
                    state_next = last_reg ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pad_reg    <= pad_next;
        neg_reg    <= neg_next;
        radix_reg  <= radix_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    // shared divider: one digit per pass
    itra_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // digit buffer; read address always points at the next digit to emit
    itra_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (n_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (AW'(n_reg - 1'b1)),
        .rdata (ram_rdata)
    );

    assign s_axis_tready   = (state_reg == S_IDLE);
    assign m_axis_tvalid   = (state_reg == S_HOLD);
    assign m_axis_tdata    = char_reg;
    assign m_axis_tlast    = last_reg;
    assign m_axis_tuser[0] = status_reg;

    // never ready for a new request while a character is pending
    `ITRA_ASSERT_NOW(a_busy_while_out, m_axis_tvalid, !s_axis_tready)
    // an error answer is a single empty character
    `ITRA_ASSERT_NOW(a_err_shape, m_axis_tvalid && m_axis_tuser[0],
                     m_axis_tlast && (m_axis_tdata == CHAR_NONE))
    // an accepted request always blocks the next cycle
    `ITRA_ASSERT_NEXT(a_accept_blocks, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // after the final character is taken the block is idle again
    `ITRA_ASSERT_NEXT(a_last_frees, m_axis_tvalid && m_axis_tready && m_axis_tlast,
                      s_axis_tready)

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for integer_to_radix_ascii: directed and random requests with
// random stalls on both stream sides, every character checked against an in-bench predictor
// depends on: itra_pkg, integer_to_radix_ascii
`timescale 1ns / 1ps

module tb;

    import itra_pkg::*;

    // digit store depth of the block under test (default parameter)
    localparam int DIGIT_SLOTS = 32;
    // command code the block does not name; it must behave as unsigned
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // ascii anchors for digit characters
    localparam logic [CHAR_W-1:0] ASCII_ZERO = "0";
    localparam logic [CHAR_W-1:0] ASCII_A    = "A";
    // longest conversion is base 2 with a sign; the settle wait runs well past it
    localparam int SETTLE_CYCLES = 400;
    localparam int DRAIN_LIMIT   = 20000;

    typedef struct {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              status;
    } char_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // value[31:0], radix[39:32], pad_length[47:40]
    logic [1:0]  s_axis_tuser = '0;    // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // character[7:0]
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;         // status[0]

    // characters still owed by the block, oldest first
    char_result_t expected_chars[$];
    char_result_t head;

    int fail_count    = 0;
    int request_count = 0;
    int char_count    = 0;
    int radix_errors  = 0;

    // random idling on each side; switched off for the closing part of the run
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int sink_burst   = 0;

    integer_to_radix_ascii i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // work out the characters one request produces and queue them
    function automatic void predict_chars(input logic [1:0] cmd, input logic [31:0] value,
                                          input logic [7:0] radix, input logic [7:0] pad);
        logic [DIGIT_W-1:0] digits [DIGIT_SLOTS];
        logic [31:0]        mag;
        logic [31:0]        base;
        int unsigned        n;
        int unsigned        pad_sat;
        logic               negative;
        char_result_t       c;
        mag      = value;
        base     = {24'd0, radix};
        negative = 1'b0;
        n        = 0;
        // bad radix: one error character, digit store untouched
        if (radix < RADIX_MIN || radix > RADIX_MAX)
        begin
            c.character = CHAR_NONE;
            c.last      = 1'b1;
            c.status    = STATUS_RADIX_ERR;
            expected_chars.push_back(c);
            radix_errors++;
            return;
        end
        // magnitude taken unsigned so the most negative value survives negation
        if (cmd == CMD_SIGNED && mag[31])
        begin
            negative = 1'b1;
            mag      = ~mag + 32'd1;
        end
        // least significant digit first; a zero value still yields one digit
        do
        begin
            digits[n] = DIGIT_W'(mag % base);
            n++;
            mag = mag / base;
        end while (mag != 0 && n < DIGIT_SLOTS);
        // zero padding only in padded mode, saturated at the store depth
        if (cmd == CMD_PADDED)
        begin
            pad_sat = (pad > DIGIT_SLOTS) ? DIGIT_SLOTS : pad;
            while (n < pad_sat)
            begin
                digits[n] = '0;
                n++;
            end
        end
        c.status = STATUS_OK;
        if (negative)
        begin
            c.character = CHAR_MINUS;
            c.last      = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = n; i > 0; i--)
        begin
            c.character = (digits[i-1] < 10) ? CHAR_W'(ASCII_ZERO + digits[i-1])
                                             : CHAR_W'(ASCII_A + digits[i-1] - 10);
            c.last      = (i == 1);
            expected_chars.push_back(c);
        end
    endfunction

    // present one request, optionally after a random idle burst, and hold it until taken
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] value,
                                input logic [7:0] radix, input logic [7:0] pad);
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pad, radix, value};
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
        predict_chars(cmd, value, radix, pad);
        request_count++;
    endtask

    // drop valid and hold off until every owed character has come out
    task automatic wait_drained();
        int cycles;
        cycles = 0;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (expected_chars.size() != 0)
        begin
            $error("%0d characters never arrived", expected_chars.size());
            fail_count++;
        end
    endtask

    // extremes of every field, every command and each corner of the conversion
    task automatic test_directed();
        send_request(CMD_UNSIGNED, 32'd0, 8'd10, 8'd0);          // zero gives a single '0'
        send_request(CMD_SIGNED,   32'd0, 8'd2, 8'd0);
        send_request(CMD_PADDED,   32'd0, 8'd16, 8'd0);           // zero, no padding asked
        send_request(CMD_UNSIGNED, 32'hFFFF_FFFF, 8'd2, 8'd0);    // 32 binary digits
        send_request(CMD_UNSIGNED, 32'hFFFF_FFFF, 8'd16, 8'd0);
        send_request(CMD_UNSIGNED, 32'hFEDC_BA98, 8'd16, 8'd0);   // every letter digit
        send_request(CMD_UNSIGNED, 32'h7654_3210, 8'd16, 8'd0);
        send_request(CMD_SIGNED,   32'h8000_0000, 8'd2, 8'd0);    // most negative, 33 chars
        send_request(CMD_SIGNED,   32'h8000_0000, 8'd10, 8'd0);
        send_request(CMD_SIGNED,   32'hFFFF_FFFF, 8'd10, 8'd0);   // minus one
        send_request(CMD_SIGNED,   32'h7FFF_FFFF, 8'd10, 8'd0);   // largest positive
        send_request(CMD_UNSIGNED, 32'h8000_0000, 8'd10, 8'd0);   // sign bit ignored
        send_request(CMD_PADDED,   32'd7, 8'd10, 8'd5);
        send_request(CMD_PADDED,   32'd1, 8'd2, 8'd32);           // full store of padding
        send_request(CMD_PADDED,   32'hABC, 8'd16, 8'd255);       // padding saturates
        send_request(CMD_PADDED,   32'd123456, 8'd10, 8'd3);      // pad shorter than value
        send_request(CMD_UNSIGNED, 32'd42, 8'd10, 8'd20);         // pad ignored unsigned
        send_request(CMD_SIGNED,   32'hFFFF_FFD6, 8'd10, 8'd20);  // pad ignored signed
        send_request(CMD_UNUSED,   32'hFFFF_FFFF, 8'd8, 8'd20);   // acts as unsigned
        send_request(CMD_UNSIGNED, 32'd99, 8'd0, 8'd0);           // radix errors
        send_request(CMD_SIGNED,   32'd99, 8'd1, 8'd0);
        send_request(CMD_PADDED,   32'd99, 8'd17, 8'd8);
        send_request(CMD_UNSIGNED, 32'd99, 8'd255, 8'd255);
        send_request(CMD_UNSIGNED, 32'd35, 8'd3, 8'd0);           // odd radix
    endtask

    // a few requests, a full drain, then more: the block restarts from idle
    task automatic test_restart_after_drain();
        send_request(CMD_SIGNED, 32'hFFFF_FC18, 8'd10, 8'd0);
        send_request(CMD_PADDED, 32'h1F, 8'd2, 8'd12);
        wait_drained();
        send_request(CMD_UNSIGNED, 32'd0, 8'd16, 8'd0);
        send_request(CMD_UNSIGNED, 32'd12345, 8'd7, 8'd0);
        wait_drained();
    endtask

    // random requests, mostly well formed with varied values and paddings
    task automatic test_random(input int count);
        logic [1:0]  cmd;
        logic [31:0] value;
        logic [7:0]  radix;
        logic [7:0]  pad;
        for (int k = 0; k < count; k++)
        begin
            cmd = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: value = $urandom();
                1: value = $urandom_range(0, 255);
                2: value = 32'h8000_0000 + $urandom_range(0, 8) - 4;
                default: value = $urandom() >> $urandom_range(0, 31);
            endcase
            radix = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(2, 16));
            pad   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 34));
            send_request(cmd, value, radix, pad);
        end
    endtask

    // output side: random bursts of stall and ready, always ready when idling is off
    always @(negedge clk)
    begin
        if (!sink_idle_on)
            m_axis_tready <= 1'b1;
        else if (sink_burst == 0)
        begin
            sink_burst    <= $urandom_range(1, 8);
            m_axis_tready <= ($urandom_range(0, 2) != 0);
        end
        else
            sink_burst <= sink_burst - 1;
    end

    // compare each character taken from the block with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character %h with nothing pending", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                head = expected_chars.pop_front();
                char_count++;
                if (m_axis_tdata !== head.character)
                begin
                    $error("character: expected %h, got %h", head.character, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== head.last)
                begin
                    $error("last: expected %b, got %b", head.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== head.status)
                begin
                    $error("status: expected %b, got %b", head.status, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_restart_after_drain();
        test_random(102);

        // closing part with both sides running flat out
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random(30);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d characters checked, %0d bad-radix answers",
                 request_count, char_count, radix_errors);
        $display("covered all commands, radices 0..255, padding to saturation, stalls both sides");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d characters outstanding", expected_chars.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
